/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 16;
    localparam int PRI_W     = 16;

    typedef logic [ID_W-1:0]         id_t;
    typedef logic signed [PRI_W-1:0] pri_t;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_CHANGE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_REMOVE = 2'd1,
        CELL_INSERT = 2'd2
    } cell_op_t;

    typedef enum logic {
        PH_IDLE   = 1'b0,
        PH_INSERT = 1'b1
    } phase_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t op;
        logic     extract;
        id_t      key_id;
        pri_t     key_pri;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic               occ,
    input  wire logic               hit_prev,
    output logic                    hit,
    input  wire logic               place_prev,
    output logic                    place,
    input  wire spq_pkg::id_t       left_id,
    input  wire spq_pkg::pri_t      left_pri,
    input  wire spq_pkg::id_t       right_id,
    input  wire spq_pkg::pri_t      right_pri,
    output spq_pkg::id_t            cell_id,
    output spq_pkg::pri_t           cell_pri
);

    spq_pkg::id_t  id_reg;
    spq_pkg::id_t  id_next;
    spq_pkg::pri_t pri_reg;
    spq_pkg::pri_t pri_next;
    logic          match;

    always_comb
    begin
        match = occ && (ctrl.extract || (id_reg == ctrl.key_id));
        hit   = hit_prev || match;
        place = !occ || (pri_reg >= ctrl.key_pri);
    end

    always_comb
    begin
        id_next  = id_reg;
        pri_next = pri_reg;
        case (ctrl.op)
            spq_pkg::CELL_REMOVE:
            begin
                if (hit)
                begin
                    id_next  = right_id;
                    pri_next = right_pri;
                end
            end
            spq_pkg::CELL_INSERT:
            begin
                if (place_prev)
                begin
                    id_next  = left_id;
                    pri_next = left_pri;
                end
                else if (place)
                begin
                    id_next  = ctrl.key_id;
                    pri_next = ctrl.key_pri;
                end
            end
            default:
            begin
                id_next  = id_reg;
                pri_next = pri_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

    assign cell_id  = id_reg;
    assign cell_pri = pri_reg;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Channel   Handshake           Word
// command   start / busy        command, entry_id, priority_req
// result    done (one cycle)    status, head_id, head_priority, is_empty, fill
//
// Extract, remove and change run the removal pass across the cell row at the accepting
// edge; insert and change run the insertion pass at the next edge, while busy is high.
// The result is shown for one cycle after that, and a new command may be accepted then.
// Reset clears the fill count and the control state; cell contents are not cleared.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  command,
    input  wire logic [spq_pkg::ID_W-1:0]    entry_id,
    input  wire logic signed [spq_pkg::PRI_W-1:0] priority_req,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [spq_pkg::ID_W-1:0]         head_id,
    output logic signed [spq_pkg::PRI_W-1:0] head_priority,
    output logic                             is_empty,
    output logic [CNT_W-1:0]                 fill
);

    spq_pkg::phase_t     state_reg;
    spq_pkg::phase_t     state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic                done_next;
    spq_pkg::status_t    status_reg;
    spq_pkg::status_t    status_next;
    logic [1:0]          cmd_reg;
    logic [1:0]          cmd_next;
    spq_pkg::id_t        id_reg;
    spq_pkg::id_t        id_next;
    spq_pkg::pri_t       pri_reg;
    spq_pkg::pri_t       pri_next;
    logic                found_reg;
    logic                found_next;
    logic                accept;
    logic                found;
    spq_pkg::cell_ctrl_t ctrl;

    logic                occ   [DEPTH];
    logic                hit   [DEPTH];
    logic                place [DEPTH];
    spq_pkg::id_t        ids   [DEPTH];
    spq_pkg::pri_t       pris  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign occ[g] = count_reg > CNT_W'(g);
            if (g == 0)
            begin : g_first
                spq_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[g]),
                    .hit_prev   (1'b0),
                    .hit        (hit[g]),
                    .place_prev (1'b0),
                    .place      (place[g]),
                    .left_id    ('0),
                    .left_pri   ('0),
                    .right_id   (ids[g+1]),
                    .right_pri  (pris[g+1]),
                    .cell_id    (ids[g]),
                    .cell_pri   (pris[g])
                );
            end
            else if (g == DEPTH - 1)
            begin : g_last
                spq_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[g]),
                    .hit_prev   (hit[g-1]),
                    .hit        (hit[g]),
                    .place_prev (place[g-1]),
                    .place      (place[g]),
                    .left_id    (ids[g-1]),
                    .left_pri   (pris[g-1]),
                    .right_id   (ids[g]),
                    .right_pri  (pris[g]),
                    .cell_id    (ids[g]),
                    .cell_pri   (pris[g])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[g]),
                    .hit_prev   (hit[g-1]),
                    .hit        (hit[g]),
                    .place_prev (place[g-1]),
                    .place      (place[g]),
                    .left_id    (ids[g-1]),
                    .left_pri   (pris[g-1]),
                    .right_id   (ids[g+1]),
                    .right_pri  (pris[g+1]),
                    .cell_id    (ids[g]),
                    .cell_pri   (pris[g])
                );
            end
        end
    endgenerate

    assign found = hit[DEPTH-1];

    always_comb
    begin
        case (state_reg)
            spq_pkg::PH_IDLE:   state_next = start ? spq_pkg::PH_INSERT : spq_pkg::PH_IDLE;
            spq_pkg::PH_INSERT: state_next = spq_pkg::PH_IDLE;
            default:            state_next = spq_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        accept       = 1'b0;
        done_next    = 1'b0;
        count_next   = count_reg;
        status_next  = status_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        pri_next     = pri_reg;
        found_next   = found_reg;
        ctrl.op      = spq_pkg::CELL_HOLD;
        ctrl.extract = 1'b0;
        ctrl.key_id  = id_reg;
        ctrl.key_pri = pri_reg;
        case (state_reg)
            spq_pkg::PH_IDLE:
            begin
                accept       = start;
                ctrl.extract = command == spq_pkg::CMD_EXTRACT;
                ctrl.key_id  = entry_id;
                ctrl.key_pri = priority_req;
                if (accept)
                begin
                    cmd_next   = command;
                    id_next    = entry_id;
                    pri_next   = priority_req;
                    found_next = found;
                    if (command != spq_pkg::CMD_INSERT)
                    begin
                        ctrl.op    = spq_pkg::CELL_REMOVE;
                        count_next = count_reg - CNT_W'(found);
                    end
                end
            end
            spq_pkg::PH_INSERT:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
                case (cmd_reg)
                    spq_pkg::CMD_INSERT,
                    spq_pkg::CMD_CHANGE:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = spq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.op     = spq_pkg::CELL_INSERT;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = spq_pkg::ST_OK;
                        end
                    end
                    spq_pkg::CMD_EXTRACT:
                        status_next = found_reg ? spq_pkg::ST_OK : spq_pkg::ST_EMPTY;
                    default:
                        status_next = found_reg ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
                endcase
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        pri_reg    <= pri_next;
        found_reg  <= found_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign is_empty      = count_reg == '0;
    assign fill          = count_reg;
    assign head_id       = is_empty ? '0 : ids[0];
    assign head_priority = is_empty ? '0 : pris[0];

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic [1:0]                  status,
    input wire logic [spq_pkg::ID_W-1:0]    head_id,
    input wire logic signed [spq_pkg::PRI_W-1:0] head_priority,
    input wire logic                        is_empty,
    input wire logic [CNT_W-1:0]            fill
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result word did not follow the busy cycle");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (fill == '0))
                 && (!is_empty || (head_id == '0 && head_priority == '0)))
        else $error("empty flag, fill and head disagree");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == spq_pkg::ST_FULL |-> fill == CNT_W'(DEPTH))
        else $error("full status while table not full");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .head_id       (head_id),
    .head_priority (head_priority),
    .is_empty      (is_empty),
    .fill          (fill)
);

`default_nettype wire

/* dv/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int TABLE_DEPTH  = spq_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        spq_pkg::cmd_t cmd;
        spq_pkg::id_t  id;
        spq_pkg::pri_t pri;
    } command_word_t;

    typedef struct {
        spq_pkg::status_t status;
        spq_pkg::id_t     head_id;
        spq_pkg::pri_t    head_pri;
        logic             is_empty;
        logic [4:0]       fill;
    } queue_report_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [1:0]    command = spq_pkg::CMD_INSERT;
    spq_pkg::id_t  entry_id = '0;
    spq_pkg::pri_t priority_req = '0;
    logic          busy;
    logic          done;
    logic [1:0]    status;
    spq_pkg::id_t  head_id;
    spq_pkg::pri_t head_priority;
    logic          is_empty;
    logic [4:0]    fill;

    command_word_t pending_commands[$];
    queue_report_t expected_reports[$];

    spq_pkg::id_t  shadow_ids[TABLE_DEPTH];
    spq_pkg::pri_t shadow_pris[TABLE_DEPTH];
    int            shadow_count = 0;

    int error_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int words_sent = 0;
    int reports_seen = 0;
    int peak_fill = 0;
    int cmd_seen[4] = '{0, 0, 0, 0};
    int status_seen[4] = '{0, 0, 0, 0};

    sorted_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .entry_id      (entry_id),
        .priority_req  (priority_req),
        .done          (done),
        .status        (status),
        .head_id       (head_id),
        .head_priority (head_priority),
        .is_empty      (is_empty),
        .fill          (fill)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_word(spq_pkg::cmd_t cmd, spq_pkg::id_t id, spq_pkg::pri_t pri);
        command_word_t word;
        word.cmd = cmd;
        word.id  = id;
        word.pri = pri;
        pending_commands.push_back(word);
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_ids[i]  = shadow_ids[i + 1];
            shadow_pris[i] = shadow_pris[i + 1];
        end
        shadow_count--;
    endfunction

    function automatic spq_pkg::status_t queue_insert(spq_pkg::id_t id, spq_pkg::pri_t pri);
        int pos;
        pos = 0;
        if (shadow_count >= TABLE_DEPTH)
            return spq_pkg::ST_FULL;
        while (pos < shadow_count && shadow_pris[pos] < pri)
            pos++;
        for (int i = shadow_count; i > pos; i--)
        begin
            shadow_ids[i]  = shadow_ids[i - 1];
            shadow_pris[i] = shadow_pris[i - 1];
        end
        shadow_ids[pos]  = id;
        shadow_pris[pos] = pri;
        shadow_count++;
        return spq_pkg::ST_OK;
    endfunction

    function automatic bit queue_remove(spq_pkg::id_t id);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_ids[i] == id)
            begin
                drop_slot(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic queue_report_t predict_queue_report(command_word_t word);
        queue_report_t report;
        report.status = spq_pkg::ST_OK;
        case (word.cmd)
            spq_pkg::CMD_INSERT:
                report.status = queue_insert(word.id, word.pri);
            spq_pkg::CMD_EXTRACT:
                if (shadow_count == 0)
                    report.status = spq_pkg::ST_EMPTY;
                else
                    drop_slot(0);
            spq_pkg::CMD_REMOVE:
                report.status = queue_remove(word.id) ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
            default:
            begin
                void'(queue_remove(word.id));
                report.status = queue_insert(word.id, word.pri);
            end
        endcase
        report.head_id  = (shadow_count != 0) ? shadow_ids[0] : '0;
        report.head_pri = (shadow_count != 0) ? shadow_pris[0] : '0;
        report.is_empty = (shadow_count == 0);
        report.fill     = shadow_count[4:0];
        return report;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        command_word_t word;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                word.cmd = spq_pkg::cmd_t'(command);
                word.id  = entry_id;
                word.pri = priority_req;
                expected_reports.push_back(predict_queue_report(word));
                if (shadow_count > peak_fill)
                    peak_fill = shadow_count;
                cmd_seen[command]++;
                words_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (pending_commands.size() != 0)
                begin
                    word = pending_commands.pop_front();
                    command      <= word.cmd;
                    entry_id     <= word.id;
                    priority_req <= word.pri;
                    start        <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        queue_report_t want;
        if (rst_n && done)
        begin
            reports_seen++;
            status_seen[status]++;
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected, status %0h head_id %0h",
                         $time, status, head_id);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("status", 16'(want.status), 16'(status));
                check_field("head_id", want.head_id, head_id);
                check_field("head_priority", want.head_pri, head_priority);
                check_field("is_empty", 16'(want.is_empty), 16'(is_empty));
                check_field("fill", 16'(want.fill), 16'(fill));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int            made;
        int            phase_len;
        int            insert_pct;
        int            pick;
        spq_pkg::cmd_t cmd;
        spq_pkg::id_t  id;
        spq_pkg::pri_t pri;

        // Directed opening: empty queue, extremes, ties, then a full table.
        add_word(spq_pkg::CMD_EXTRACT, 16'h0000, 16'h0000);
        add_word(spq_pkg::CMD_REMOVE, 16'h1234, 16'h0000);
        add_word(spq_pkg::CMD_CHANGE, 16'h0005, 16'h0000);
        add_word(spq_pkg::CMD_INSERT, 16'hFFFF, 16'h7FFF);
        add_word(spq_pkg::CMD_INSERT, 16'h0000, 16'h8000);
        add_word(spq_pkg::CMD_INSERT, 16'h0001, 16'h8000);
        add_word(spq_pkg::CMD_CHANGE, 16'h0000, 16'h7FFF);
        add_word(spq_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000);
        for (int i = 0; i < 13; i++)
            add_word(spq_pkg::CMD_INSERT, spq_pkg::id_t'(16'h0100 + i),
                     spq_pkg::pri_t'(i * 37 - 200));
        add_word(spq_pkg::CMD_INSERT, 16'h0007, 16'h0000);
        add_word(spq_pkg::CMD_CHANGE, 16'hBEEF, 16'h0000);
        add_word(spq_pkg::CMD_CHANGE, 16'h0100, 16'hFFFF);
        add_word(spq_pkg::CMD_EXTRACT, 16'h0000, 16'h0000);

        // Random phases each pick a fill-heavy, balanced or drain-heavy mix of commands.
        made = 0;
        while (made < RANDOM_WORDS)
        begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 20;
            endcase
            for (int i = 0; i < phase_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < insert_pct)
                    cmd = spq_pkg::CMD_INSERT;
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       cmd = spq_pkg::CMD_EXTRACT;
                        1:       cmd = spq_pkg::CMD_REMOVE;
                        default: cmd = spq_pkg::CMD_CHANGE;
                    endcase
                end
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    id = spq_pkg::id_t'($urandom_range(0, 23));
                else if (pick == 8)
                    id = spq_pkg::id_t'($urandom);
                else
                    id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    pri = spq_pkg::pri_t'($urandom_range(0, 8) - 4);
                else if (pick < 17)
                    pri = spq_pkg::pri_t'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       pri = 16'h8000;
                        1:       pri = 16'h7FFF;
                        2:       pri = 16'hFFFF;
                        default: pri = 16'h0000;
                    endcase
                end
                add_word(cmd, id, pri);
                made++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_commands.size() != 0 || start || expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d insert, %0d extract, %0d remove, %0d change key.",
                 words_sent, cmd_seen[spq_pkg::CMD_INSERT], cmd_seen[spq_pkg::CMD_EXTRACT],
                 cmd_seen[spq_pkg::CMD_REMOVE], cmd_seen[spq_pkg::CMD_CHANGE]);
        $display("Results: %0d ok, %0d full, %0d not found, %0d empty; peak fill %0d.",
                 status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_FULL],
                 status_seen[spq_pkg::ST_NOT_FOUND], status_seen[spq_pkg::ST_EMPTY], peak_fill);
        if (error_count == 0 && reports_seen == words_sent)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
